// ----- hw/rtl/header_body_message_parser_assert.svh -----
// Assertion macros shared by the parser RTL.
`ifndef HEADER_BODY_MESSAGE_PARSER_ASSERT_SVH
`define HEADER_BODY_MESSAGE_PARSER_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define HBMP_ASSERT_ALWAYS(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent holds at the clock edge after the antecedent.
`define HBMP_ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ----- hw/rtl/hbmp_pkg.sv -----
package hbmp_pkg;

    localparam int LINE_BITS_DEF = 16;
    localparam int OUT_DEPTH     = 4;

    typedef enum logic [3:0] {
        ST_START      = 4'd0,
        ST_TITLE      = 4'd1,
        ST_NAME       = 4'd2,
        ST_VALUE      = 4'd3,
        ST_LINE_START = 4'd4,
        ST_FOLD       = 4'd5,
        ST_BODY       = 4'd6,
        ST_DONE       = 4'd7,
        ST_HALT       = 4'd8
    } t_state;

    localparam logic [2:0] EV_HEADLINE_BYTE = 3'd0;
    localparam logic [2:0] EV_HEADLINE_END  = 3'd1;
    localparam logic [2:0] EV_NAME_BYTE     = 3'd2;
    localparam logic [2:0] EV_VALUE_BYTE    = 3'd3;
    localparam logic [2:0] EV_HEADER_END    = 3'd4;
    localparam logic [2:0] EV_BODY_BYTE     = 3'd5;
    localparam logic [2:0] EV_FINISHED      = 3'd6;
    localparam logic [2:0] EV_ERROR         = 3'd7;

    localparam logic [2:0] ERR_NONE          = 3'd0;
    localparam logic [2:0] ERR_HEADLINE      = 3'd1;
    localparam logic [2:0] ERR_UNEXPECTED    = 3'd2;
    localparam logic [2:0] ERR_SPACE_IN_NAME = 3'd3;
    localparam logic [2:0] ERR_NO_COLON      = 3'd4;
    localparam logic [2:0] ERR_HEADER_LINE   = 3'd5;
    localparam logic [2:0] ERR_AFTER_FINISH  = 3'd6;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data;
        logic [2:0]  code;
        logic [15:0] line;
        logic        last;
    } t_result;

    function automatic t_result mk_res(logic [2:0] kind, logic [7:0] data,
                                       logic [2:0] code, logic [15:0] line);
        t_result r;
        r.kind = kind;
        r.data = data;
        r.code = code;
        r.line = line;
        r.last = 1'b0;
        return r;
    endfunction

endpackage

// ----- hw/rtl/header_body_message_parser.sv -----
// Latency: a result can be taken in the cycle after its transaction is accepted.
// Throughput: one input transaction per cycle while o_ready is high; the parse step is one
// state update. The four-entry result queue drains one result per cycle while i_ready is
// high; items can give two results, so input waits while fewer than two slots are free.
// Reset (synchronous, active low) empties the queue, returns to the start state,
// sets the line number to one and clears the heading-line enable.
module header_body_message_parser
    import hbmp_pkg::*;
#(
    parameter int LINE_BITS = LINE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_text,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_event_kind,
    output logic [7:0]  o_out_byte,
    output logic [2:0]  o_err_code,
    output logic [15:0] o_err_line,
    output logic        o_last_of_run
);

`include "header_body_message_parser_assert.svh"

    localparam int PTR_W = $clog2(OUT_DEPTH);
    localparam int CNT_W = $clog2(OUT_DEPTH + 1);
    localparam logic [CNT_W-1:0] READY_MAX = CNT_W'(OUT_DEPTH - 2);
    localparam logic [CNT_W-1:0] DEPTH_C   = CNT_W'(OUT_DEPTH);

    t_state                r_state,    n_state;
    logic                  r_name_ne,  n_name_ne;
    logic                  r_val_lead, n_val_lead;
    logic [LINE_BITS-1:0]  r_line,     n_line;
    logic [2:0]            r_saved,    n_saved;
    logic                  r_hl_en;

    t_result               r_queue [OUT_DEPTH];
    logic [PTR_W-1:0]      r_wr_ptr;
    logic [PTR_W-1:0]      r_rd_ptr;
    logic [CNT_W-1:0]      r_count;

    t_result               res [2];
    logic [1:0]            cnt;
    logic                  do_name;
    logic                  name_ne;
    logic                  ws;
    logic                  eot;
    logic [7:0]            c;
    logic [LINE_BITS+15:0] line_ext;
    logic [15:0]           err_line;
    logic                  in_acc;
    logic                  out_acc;
    logic [PTR_W-1:0]      wr_ptr_1;

    assign c        = i_data_byte;
    assign eot      = i_end_of_text;
    assign ws       = c inside {CH_SPACE, CH_TAB, CH_CR};
    assign line_ext = {16'b0, r_line};
    assign err_line = line_ext[15:0];
    assign in_acc   = i_valid && o_ready;
    assign out_acc  = o_valid && i_ready;
    assign wr_ptr_1 = r_wr_ptr + PTR_W'(1);

    always_comb begin
        n_state    = r_state;
        n_name_ne  = r_name_ne;
        n_val_lead = r_val_lead;
        n_saved    = r_saved;
        n_line     = r_line;
        res[0]     = '0;
        res[1]     = '0;
        cnt        = 2'd0;
        do_name    = 1'b0;
        name_ne    = r_name_ne;

        case (r_state)
            ST_START: begin
                if (eot) begin
                    n_state     = ST_DONE;
                    res[cnt[0]] = mk_res(EV_FINISHED, 8'd0, ERR_NONE, 16'd0);
                    cnt         = cnt + 2'd1;
                end else if (!ws && c != CH_LF) begin
                    if (r_hl_en) begin
                        n_state     = ST_TITLE;
                        res[cnt[0]] = mk_res(EV_HEADLINE_BYTE, c, ERR_NONE, 16'd0);
                        cnt         = cnt + 2'd1;
                    end else begin
                        do_name = 1'b1;
                        name_ne = 1'b0;
                    end
                end
            end
            ST_TITLE: begin
                if (eot) begin
                    n_state     = ST_HALT;
                    n_saved     = ERR_HEADLINE;
                    res[cnt[0]] = mk_res(EV_ERROR, 8'd0, ERR_HEADLINE, err_line);
                    cnt         = cnt + 2'd1;
                end else if (c == CH_LF) begin
                    n_state     = ST_NAME;
                    n_name_ne   = 1'b0;
                    res[cnt[0]] = mk_res(EV_HEADLINE_END, 8'd0, ERR_NONE, 16'd0);
                    cnt         = cnt + 2'd1;
                end else if (c != CH_CR) begin
                    res[cnt[0]] = mk_res(EV_HEADLINE_BYTE, c, ERR_NONE, 16'd0);
                    cnt         = cnt + 2'd1;
                end
            end
            ST_NAME: begin
                do_name = 1'b1;
            end
            ST_VALUE: begin
                if (eot) begin
                    n_state     = ST_HALT;
                    n_saved     = ERR_HEADER_LINE;
                    res[cnt[0]] = mk_res(EV_ERROR, 8'd0, ERR_HEADER_LINE, err_line);
                    cnt         = cnt + 2'd1;
                end else if (c == CH_LF) begin
                    n_state = ST_LINE_START;
                end else if (c != CH_CR) begin
                    if (!(r_val_lead && (c == CH_SPACE || c == CH_TAB))) begin
                        n_val_lead  = 1'b0;
                        res[cnt[0]] = mk_res(EV_VALUE_BYTE, c, ERR_NONE, 16'd0);
                        cnt         = cnt + 2'd1;
                    end
                end
            end
            ST_LINE_START: begin
                if (eot) begin
                    n_state     = ST_DONE;
                    res[0]      = mk_res(EV_HEADER_END, 8'd0, ERR_NONE, 16'd0);
                    res[1]      = mk_res(EV_FINISHED, 8'd0, ERR_NONE, 16'd0);
                    cnt         = 2'd2;
                end else if (ws) begin
                    n_state = ST_FOLD;
                end else begin
                    res[cnt[0]] = mk_res(EV_HEADER_END, 8'd0, ERR_NONE, 16'd0);
                    cnt         = cnt + 2'd1;
                    if (c == CH_LF) begin
                        n_state = ST_BODY;
                    end else begin
                        do_name = 1'b1;
                        name_ne = 1'b0;
                    end
                end
            end
            ST_FOLD: begin
                if (eot) begin
                    n_state = ST_DONE;
                    res[0]  = mk_res(EV_HEADER_END, 8'd0, ERR_NONE, 16'd0);
                    res[1]  = mk_res(EV_FINISHED, 8'd0, ERR_NONE, 16'd0);
                    cnt     = 2'd2;
                end else if (c == CH_LF) begin
                    n_state     = ST_BODY;
                    res[cnt[0]] = mk_res(EV_HEADER_END, 8'd0, ERR_NONE, 16'd0);
                    cnt         = cnt + 2'd1;
                end else if (!ws) begin
                    n_state    = ST_VALUE;
                    n_val_lead = 1'b0;
                    res[0]     = mk_res(EV_VALUE_BYTE, CH_LF, ERR_NONE, 16'd0);
                    res[1]     = mk_res(EV_VALUE_BYTE, c, ERR_NONE, 16'd0);
                    cnt        = 2'd2;
                end
            end
            ST_BODY: begin
                if (eot) begin
                    n_state     = ST_DONE;
                    res[cnt[0]] = mk_res(EV_FINISHED, 8'd0, ERR_NONE, 16'd0);
                    cnt         = cnt + 2'd1;
                end else begin
                    res[cnt[0]] = mk_res(EV_BODY_BYTE, c, ERR_NONE, 16'd0);
                    cnt         = cnt + 2'd1;
                end
            end
            ST_DONE: begin
                if (!eot) begin
                    n_state     = ST_HALT;
                    n_saved     = ERR_AFTER_FINISH;
                    res[cnt[0]] = mk_res(EV_ERROR, 8'd0, ERR_AFTER_FINISH, err_line);
                    cnt         = cnt + 2'd1;
                end
            end
            default: begin
            end
        endcase

        // Shared handling of one character of a header name.
        if (do_name) begin
            n_state   = ST_NAME;
            n_name_ne = name_ne;
            if (eot) begin
                if (name_ne) begin
                    n_state     = ST_HALT;
                    n_saved     = ERR_UNEXPECTED;
                    res[cnt[0]] = mk_res(EV_ERROR, 8'd0, ERR_UNEXPECTED, err_line);
                    cnt         = cnt + 2'd1;
                end else begin
                    n_state     = ST_DONE;
                    res[cnt[0]] = mk_res(EV_FINISHED, 8'd0, ERR_NONE, 16'd0);
                    cnt         = cnt + 2'd1;
                end
            end else if (ws) begin
                n_state     = ST_HALT;
                n_saved     = ERR_SPACE_IN_NAME;
                res[cnt[0]] = mk_res(EV_ERROR, 8'd0, ERR_SPACE_IN_NAME, err_line);
                cnt         = cnt + 2'd1;
            end else if (c == CH_LF) begin
                if (name_ne) begin
                    n_state     = ST_HALT;
                    n_saved     = ERR_NO_COLON;
                    res[cnt[0]] = mk_res(EV_ERROR, 8'd0, ERR_NO_COLON, err_line);
                    cnt         = cnt + 2'd1;
                end else begin
                    n_state = ST_BODY;
                end
            end else if (c == CH_COLON) begin
                n_name_ne  = 1'b0;
                n_val_lead = 1'b1;
                n_state    = ST_VALUE;
            end else begin
                n_name_ne   = 1'b1;
                res[cnt[0]] = mk_res(EV_NAME_BYTE, c, ERR_NONE, 16'd0);
                cnt         = cnt + 2'd1;
            end
        end

        if (cnt == 2'd1) begin
            res[0].last = 1'b1;
        end else if (cnt == 2'd2) begin
            res[1].last = 1'b1;
        end

        if (!eot && c == CH_LF && r_line != '1) begin
            n_line = r_line + LINE_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_START;
            r_name_ne  <= 1'b0;
            r_val_lead <= 1'b0;
            r_line     <= LINE_BITS'(1);
            r_saved    <= ERR_NONE;
        end else if (in_acc) begin
            r_state    <= n_state;
            r_name_ne  <= n_name_ne;
            r_val_lead <= n_val_lead;
            r_line     <= n_line;
            r_saved    <= n_saved;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hl_en <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_hl_en <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && cnt != 2'd0) begin
            r_queue[r_wr_ptr] <= res[0];
        end
        if (in_acc && cnt == 2'd2) begin
            r_queue[wr_ptr_1] <= res[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (in_acc) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(cnt);
            end
            if (out_acc) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + (in_acc ? CNT_W'(cnt) : CNT_W'(0))
                       - (out_acc ? CNT_W'(1) : CNT_W'(0));
        end
    end

    assign o_ready       = (r_count <= READY_MAX);
    assign o_valid       = (r_count != '0);
    assign o_event_kind  = r_queue[r_rd_ptr].kind;
    assign o_out_byte    = r_queue[r_rd_ptr].data;
    assign o_err_code    = r_queue[r_rd_ptr].code;
    assign o_err_line    = r_queue[r_rd_ptr].line;
    assign o_last_of_run = r_queue[r_rd_ptr].last;

    `HBMP_ASSERT_ALWAYS(a_queue_bound, i_clk, i_rst_n,
        r_count <= DEPTH_C, "Result queue overflow.")
    `HBMP_ASSERT_ALWAYS(a_error_saved, i_clk, i_rst_n,
        r_state != ST_HALT || r_saved != ERR_NONE, "Halt state without a saved code.")
    `HBMP_ASSERT_NEXT(a_line_monotonic, i_clk, i_rst_n,
        1'b1, r_line >= $past(r_line), "Line number went backward.")

endmodule
